[rtl/core/avp_pkg.sv]
// ----------------------------------------------------------------------------
// avp_pkg: shared types and constants of the average pooling core
// Register indexes, register widths and reset values, field widths and the
// control state type.
// ----------------------------------------------------------------------------
`default_nettype none

package avp_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int WINDOW_W    = 4;
   localparam int STRIDE_W    = 4;
   localparam int WIDTH_W     = 9;
   localparam int HEIGHT_W    = 9;
   localparam int CHANNELS_W  = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_WINDOW_SIZE   = 3'd0;
   localparam csr_index_type CSR_STRIDE        = 3'd1;
   localparam csr_index_type CSR_IMAGE_WIDTH   = 3'd2;
   localparam csr_index_type CSR_IMAGE_HEIGHT  = 3'd3;
   localparam csr_index_type CSR_CHANNEL_COUNT = 3'd4;

   localparam logic [WINDOW_W-1:0]   WINDOW_SIZE_RST   = 4'd2;
   localparam logic [STRIDE_W-1:0]   STRIDE_RST        = 4'd2;
   localparam logic [WIDTH_W-1:0]    IMAGE_WIDTH_RST   = 9'd256;
   localparam logic [HEIGHT_W-1:0]   IMAGE_HEIGHT_RST  = 9'd256;
   localparam logic [CHANNELS_W-1:0] CHANNEL_COUNT_RST = 11'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_LAUNCH,
      S_DIV
   } avp_state_type;

endpackage

`default_nettype wire

[rtl/core/average_pooling_core.sv]
// ----------------------------------------------------------------------------
// average_pooling_core: streaming 2-D average pooling over a feature map
// Running column sums in a sample row store give constant work per sample;
// window means go through a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the req_ channel (valid/stall) in raster order: channel,
//   then row, then column. Each window whose top-left corner lies on the
//   stride grid and fits inside the map yields one beat on the rsp_ channel,
//   its mean truncated toward zero; rsp_is_last flags the final window of the
//   last channel. Registers are written on the csr_ channel (valid/ready)
//   while the block is idle; any write to a listed register restarts the
//   stream at channel 0, row 0, column 0.
//   A sample passes a memory read, then update and write back; one that
//   closes a window also passes the launch and divide steps, and no new
//   sample is taken until it is through. The radix-2 divider retires one
//   quotient bit per cycle over the window sum, 22 bits at MAX_WINDOW = 8.
//   The result register parts the two sides: while rsp_stall holds a mean,
//   samples keep flowing; only the next mean waits for the register to free.
//   Reset clears the position counters and restores the register defaults
//   (window 2, stride 2, 256 x 256, one channel). The memories need no
//   clearing: every entry is written before the stream reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module average_pooling_core #(
   parameter int MAX_WINDOW   = 8,
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int MAX_CHANNELS = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // sample channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [avp_pkg::SAMPLE_W-1:0]   req_sample,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [avp_pkg::SAMPLE_W-1:0]        rsp_average,
   output logic                                       rsp_is_last,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [avp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [avp_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import avp_pkg::*;

   localparam int F_W    = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CS_W   = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int WS_W   = SAMPLE_W + 2 * $clog2(MAX_WINDOW);
   localparam int AREA_W = 2 * F_W;
   localparam int WT_W   = (F_W > STRIDE_W) ? F_W : STRIDE_W;
   // wide enough for every dimension, every register and row + 1 + stride
   localparam int DIM_A  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                           $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int DIM_B  = ($clog2(MAX_CHANNELS + 1) > CHANNELS_W) ?
                           $clog2(MAX_CHANNELS + 1) : CHANNELS_W;
   localparam int DIM_W  = ((DIM_A > DIM_B) ? DIM_A : DIM_B) + 1;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic [WINDOW_W-1:0]   window_size_ff;
   logic [STRIDE_W-1:0]   stride_ff;
   logic [WIDTH_W-1:0]    image_width_ff;
   logic [HEIGHT_W-1:0]   image_height_ff;
   logic [CHANNELS_W-1:0] channel_count_ff;

   logic csr_accept;
   logic csr_hit;
   logic restart;

   assign csr_accept = csr_valid && csr_ready;

   always_comb begin
      unique case (csr_index)
         CSR_WINDOW_SIZE, CSR_STRIDE, CSR_IMAGE_WIDTH,
         CSR_IMAGE_HEIGHT, CSR_CHANNEL_COUNT: csr_hit = 1'b1;
         default:                             csr_hit = 1'b0;
      endcase
   end

   // a write beyond the list is dropped and restarts nothing
   assign restart = csr_accept && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= WINDOW_SIZE_RST;
         stride_ff        <= STRIDE_RST;
         image_width_ff   <= IMAGE_WIDTH_RST;
         image_height_ff  <= IMAGE_HEIGHT_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:   window_size_ff   <= csr_wdata[WINDOW_W-1:0];
            CSR_STRIDE:        stride_ff        <= csr_wdata[STRIDE_W-1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata[HEIGHT_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHANNELS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry: zero acts as one, oversize saturates (stride does not)
   logic [F_W-1:0]      f_eff;
   logic [STRIDE_W-1:0] s_eff;
   logic [DIM_W-1:0]    w_eff;
   logic [DIM_W-1:0]    h_eff;
   logic [DIM_W-1:0]    c_eff;
   logic [DIM_W-1:0]    f_dim;
   logic [DIM_W-1:0]    s_dim;

   always_comb begin
      if (window_size_ff == '0) begin
         f_eff = F_W'(1);
      end else if (DIM_W'(window_size_ff) > DIM_W'(MAX_WINDOW)) begin
         f_eff = F_W'(MAX_WINDOW);
      end else begin
         f_eff = F_W'(window_size_ff);
      end

      s_eff = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;

      if (image_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (DIM_W'(image_width_ff) > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = DIM_W'(image_width_ff);
      end

      if (image_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (DIM_W'(image_height_ff) > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = DIM_W'(image_height_ff);
      end

      if (channel_count_ff == '0) begin
         c_eff = DIM_W'(1);
      end else if (DIM_W'(channel_count_ff) > DIM_W'(MAX_CHANNELS)) begin
         c_eff = DIM_W'(MAX_CHANNELS);
      end else begin
         c_eff = DIM_W'(channel_count_ff);
      end
   end

   assign f_dim = DIM_W'(f_eff);
   assign s_dim = DIM_W'(s_eff);

   // ------------------------------------------------------------------------
   // control
   // ------------------------------------------------------------------------
   avp_state_type state_ff;
   avp_state_type state_in;

   logic req_accept;
   logic rd_en;
   logic wr_en;
   logic div_start;
   logic div_done;
   logic load_out;

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   logic emit;
   logic rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (req_valid) begin
               rd_en    = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            // update sums, write back, advance the position
            wr_en    = 1'b1;
            state_in = emit ? S_LAUNCH : S_IDLE;
         end
         S_LAUNCH: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            // hold the mean until the result register frees
            if (div_done && (!rsp_valid_ff || !rsp_stall)) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // stream position
   // ------------------------------------------------------------------------
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [SLOT_W-1:0] cslot_ff;   // column mod MAX_WINDOW
   logic [SLOT_W-1:0] rslot_ff;   // row mod MAX_WINDOW
   logic [WT_W-1:0]   cwait_ff;   // columns left to the next window column
   logic [WT_W-1:0]   rwait_ff;   // rows left to the next window row

   logic [DIM_W-1:0] col_dim;
   logic [DIM_W-1:0] row_dim;
   logic [DIM_W-1:0] ch_dim;
   logic             first_col;
   logic             first_row;
   logic [WT_W-1:0]  cwait_cur;
   logic [WT_W-1:0]  rwait_cur;
   logic             col_last;
   logic             row_last;
   logic             ch_last;
   logic             row_ge_f;
   logic             col_ge_f;
   logic             is_last_now;

   assign col_dim   = DIM_W'(col_ff);
   assign row_dim   = DIM_W'(row_ff);
   assign ch_dim    = DIM_W'(ch_ff);
   assign first_col = (col_ff == '0);
   assign first_row = (row_ff == '0);
   // the countdown starts at F-1 at the head of each row and each channel
   assign cwait_cur = first_col ? WT_W'(f_eff) - WT_W'(1) : cwait_ff;
   assign rwait_cur = first_row ? WT_W'(f_eff) - WT_W'(1) : rwait_ff;
   assign emit      = (cwait_cur == '0) && (rwait_cur == '0);
   assign col_last  = (col_dim + DIM_W'(1)) >= w_eff;
   assign row_last  = (row_dim + DIM_W'(1)) >= h_eff;
   assign ch_last   = (ch_dim + DIM_W'(1)) >= c_eff;
   assign row_ge_f  = row_dim >= f_dim;
   assign col_ge_f  = col_dim >= f_dim;
   assign is_last_now = ch_last && (row_dim + DIM_W'(1) + s_dim > h_eff) &&
                        (col_dim + DIM_W'(1) + s_dim > w_eff);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff   <= '0;
         row_ff   <= '0;
         ch_ff    <= '0;
         cslot_ff <= '0;
         rslot_ff <= '0;
         cwait_ff <= '0;
         rwait_ff <= '0;
      end else if (state_ff == S_CALC) begin
         if (col_last) begin
            col_ff   <= '0;
            cslot_ff <= '0;
            if (row_last) begin
               row_ff   <= '0;
               rslot_ff <= '0;
               ch_ff    <= ch_last ? '0 : ch_ff + CH_W'(1);
            end else begin
               row_ff   <= row_ff + ROW_W'(1);
               rslot_ff <= (rslot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 :
                           rslot_ff + SLOT_W'(1);
               rwait_ff <= (rwait_cur == '0) ? WT_W'(s_eff) - WT_W'(1) :
                           rwait_cur - WT_W'(1);
            end
         end else begin
            col_ff   <= col_ff + COL_W'(1);
            cslot_ff <= (cslot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 :
                        cslot_ff + SLOT_W'(1);
            cwait_ff <= (cwait_cur == '0) ? WT_W'(s_eff) - WT_W'(1) :
                        cwait_cur - WT_W'(1);
         end
      end
   end

   // slot F rows (or columns) back, mod MAX_WINDOW
   logic [F_W:0]      rs_back_raw;
   logic [F_W:0]      cs_back_raw;
   logic [SLOT_W-1:0] rs_back;
   logic [SLOT_W-1:0] cs_back;

   always_comb begin
      rs_back_raw = (F_W+1)'(rslot_ff) + (F_W+1)'(MAX_WINDOW) - (F_W+1)'(f_eff);
      cs_back_raw = (F_W+1)'(cslot_ff) + (F_W+1)'(MAX_WINDOW) - (F_W+1)'(f_eff);
      if (rs_back_raw >= (F_W+1)'(MAX_WINDOW)) begin
         rs_back = SLOT_W'(rs_back_raw - (F_W+1)'(MAX_WINDOW));
      end else begin
         rs_back = SLOT_W'(rs_back_raw);
      end
      if (cs_back_raw >= (F_W+1)'(MAX_WINDOW)) begin
         cs_back = SLOT_W'(cs_back_raw - (F_W+1)'(MAX_WINDOW));
      end else begin
         cs_back = SLOT_W'(cs_back_raw);
      end
   end

   // ------------------------------------------------------------------------
   // running sums
   // ------------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic signed [CS_W-1:0]     rd_colsum;
   logic signed [CS_W:0]       cs_wide;
   logic signed [CS_W-1:0]     cs_new;
   logic signed [WS_W:0]       ws_wide;
   logic signed [WS_W-1:0]     ws_new;
   logic signed [WS_W-1:0]     ws_ff;
   logic signed [CS_W-1:0]     recent_ff [MAX_WINDOW];
   logic signed [CS_W-1:0]     recent_old;
   logic                       last_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_sample;
      end
   end

   avp_store #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_store (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_col    (col_ff),
      .rd_slot   (rs_back),
      .wr_en     (wr_en),
      .wr_col    (col_ff),
      .wr_slot   (rslot_ff),
      .wr_sample (sample_ff),
      .wr_colsum (cs_new),
      .rd_sample (rd_sample),
      .rd_colsum (rd_colsum)
   );

   assign recent_old = recent_ff[cs_back];

   always_comb begin
      // column sum: add the new sample, drop the one that left the window
      if (first_row) begin
         cs_wide = (CS_W+1)'(sample_ff);
      end else if (row_ge_f) begin
         cs_wide = (CS_W+1)'(rd_colsum) + (CS_W+1)'(sample_ff) -
                   (CS_W+1)'(rd_sample);
      end else begin
         cs_wide = (CS_W+1)'(rd_colsum) + (CS_W+1)'(sample_ff);
      end
      cs_new = cs_wide[CS_W-1:0];

      // window sum: add the new column sum, drop the column that left
      if (first_col) begin
         ws_wide = (WS_W+1)'(cs_new);
      end else if (col_ge_f) begin
         ws_wide = (WS_W+1)'(ws_ff) + (WS_W+1)'(cs_new) - (WS_W+1)'(recent_old);
      end else begin
         ws_wide = (WS_W+1)'(ws_ff) + (WS_W+1)'(cs_new);
      end
      ws_new = ws_wide[WS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         ws_ff <= '0;
         for (int i = 0; i < MAX_WINDOW; i++) begin
            recent_ff[i] <= '0;
         end
      end else if (state_ff == S_CALC) begin
         ws_ff              <= ws_new;
         recent_ff[cslot_ff] <= cs_new;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         last_ff <= is_last_now;
      end
   end

   // ------------------------------------------------------------------------
   // mean and result register
   // ------------------------------------------------------------------------
   logic [AREA_W-1:0]          area;
   logic signed [SAMPLE_W-1:0] div_quotient;
   logic signed [SAMPLE_W-1:0] rsp_average_ff;
   logic                       rsp_is_last_ff;

   assign area = AREA_W'(f_eff) * AREA_W'(f_eff);

   avp_divider #(
      .NUM_W (WS_W),
      .DEN_W (AREA_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ws_ff),
      .divisor  (area),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_average_ff <= div_quotient;
         rsp_is_last_ff <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_is_last = rsp_is_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_col_in_map: assert property (@(posedge clock) disable iff (reset)
      col_dim < w_eff)
      else $error("column position left the map");

   a_row_in_map: assert property (@(posedge clock) disable iff (reset)
      row_dim < h_eff)
      else $error("row position left the map");

   a_ch_in_volume: assert property (@(posedge clock) disable iff (reset)
      ch_dim < c_eff)
      else $error("channel position left the volume");

   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_CALC)
      else $error("accepted beat did not enter the update step");

   a_result_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DIV)
      else $error("result raised outside the divide step");

endmodule

`default_nettype wire

[rtl/core/avp_store.sv]
// ----------------------------------------------------------------------------
// avp_store: sample row store and per-column sum memory
// Two synchronous memories with one registered read port and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module avp_store #(
   parameter int MAX_WINDOW = 8,
   parameter int MAX_WIDTH  = 256
) (
   input  wire logic                                              clock,
   input  wire logic                                              rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]                      rd_col,
   input  wire logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] rd_slot,
   input  wire logic                                              wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]                      wr_col,
   input  wire logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] wr_slot,
   input  wire logic signed [avp_pkg::SAMPLE_W-1:0]               wr_sample,
   input  wire logic signed [avp_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] wr_colsum,
   output logic signed [avp_pkg::SAMPLE_W-1:0]                    rd_sample,
   output logic signed [avp_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] rd_colsum
);
   import avp_pkg::*;

   localparam int RS_DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int RS_AW    = $clog2(RS_DEPTH);
   localparam int CS_W     = SAMPLE_W + $clog2(MAX_WINDOW);

   logic signed [SAMPLE_W-1:0] row_mem [RS_DEPTH];
   logic signed [CS_W-1:0]     col_mem [MAX_WIDTH];

   logic [RS_AW-1:0] rs_raddr;
   logic [RS_AW-1:0] rs_waddr;

   assign rs_raddr = RS_AW'(rd_slot * MAX_WIDTH + rd_col);
   assign rs_waddr = RS_AW'(wr_slot * MAX_WIDTH + wr_col);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[rs_waddr] <= wr_sample;
      end
      if (rd_en) begin
         rd_sample <= row_mem[rs_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         col_mem[wr_col] <= wr_colsum;
      end
      if (rd_en) begin
         rd_colsum <= col_mem[rd_col];
      end
   end

endmodule

`default_nettype wire

[rtl/core/avp_divider.sv]
// ----------------------------------------------------------------------------
// avp_divider: signed by unsigned restoring divider, one quotient bit a cycle
// Quotient is truncated toward zero and returned at sample width.
// ----------------------------------------------------------------------------
`default_nettype none

module avp_divider #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [NUM_W-1:0]             dividend,
   input  wire logic        [DEN_W-1:0]             divisor,
   output logic                                     done,
   output logic signed [avp_pkg::SAMPLE_W-1:0]      quotient
);
   import avp_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               neg_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;

   logic [NUM_W-1:0]    mag_in;
   logic [DEN_W:0]      rem_shift;
   logic                take;
   logic [DEN_W-1:0]    rem_in;
   logic [SAMPLE_W-1:0] q_mag;

   assign mag_in    = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign take      = rem_shift >= {1'b0, den_ff};
   assign rem_in    = take ? DEN_W'(rem_shift - {1'b0, den_ff}) : DEN_W'(rem_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         count_ff <= count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // shift dividend bits out and quotient bits in through the same register
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[NUM_W-1];
         num_ff <= mag_in;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], take};
         rem_ff <= rem_in;
      end
   end

   assign q_mag    = num_ff[SAMPLE_W-1:0];
   assign quotient = neg_ff ? signed'(SAMPLE_W'(-q_mag)) : signed'(q_mag);
   assign done     = done_ff;

endmodule

`default_nettype wire
